// File: rtl/core/twwg_pkg.sv
package twwg_pkg;

  // Command codes
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_STOP   = 3'd1;
  localparam logic [2:0] CMD_BYTE   = 3'd2;
  localparam logic [2:0] CMD_NIBBLE = 3'd3;
  localparam logic [2:0] CMD_BIT    = 3'd4;
  localparam logic [2:0] CMD_WORD   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_BIT_HALF_PERIOD = 1'b0;
  localparam logic CFG_EDGE_SETUP_TIME = 1'b1;

  localparam logic [7:0] BIT_HALF_PERIOD_RST = 8'd1;
  localparam logic [7:0] EDGE_SETUP_TIME_RST = 8'd4;

  // Bit shifter: a word is two bytes, each followed by an ack bit
  localparam int SHIFT_W = 18;
  localparam int COUNT_W = 5;

  // Phase codes within one bit or one start/stop condition
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  typedef logic [2:0]  cmd_t;
  typedef logic [15:0] payload_t;
  typedef logic [7:0]  ticks_t;

endpackage

// File: rtl/core/twwg_in_if.sv
interface twwg_in_if;
  logic              valid;
  logic              ready;
  twwg_pkg::cmd_t     cmd;
  twwg_pkg::payload_t payload;

  modport source (output valid, output cmd, output payload, input ready);
  modport sink (input valid, input cmd, input payload, output ready);
endinterface

// File: rtl/core/twwg_out_if.sv
interface twwg_out_if;
  logic             valid;
  logic             ready;
  logic             clock_level;
  logic             data_level;
  twwg_pkg::ticks_t hold_ticks;
  logic             last_phase;

  modport source (output valid, output clock_level, output data_level,
                  output hold_ticks, output last_phase, input ready);
  modport sink (input valid, input clock_level, input data_level,
                input hold_ticks, input last_phase, output ready);
endinterface

// File: rtl/core/two_wire_write_waveform_generator.sv
// Write-only two-wire bus waveform generator. Each command beat on in_bus
// (start, stop, byte plus ack, nibble, single bit, or word as two acked
// bytes) produces a list of pin-phase beats on out_bus giving clock level,
// data level and hold ticks; last_phase marks the final beat of a command.
// Data bits are loaded into an 18-bit shift register and leave it MSB
// first, one bit per three output beats, so a command yields one beat per
// cycle when the sink is ready: 3 beats for start, stop or a single bit,
// 12 for a nibble, 27 for a byte and 54 for a word. A new command is
// taken once the final beat of the previous one sits in the output
// register. Codes 6 and 7 are accepted and produce nothing.
// bit_half_period and edge_setup_time are written through
// cfg_we/cfg_idx/cfg_data; the user must write them only while idle,
// as the block itself does not enforce it.
module two_wire_write_waveform_generator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [7:0]       cfg_data,
  twwg_in_if.sink          in_bus,
  twwg_out_if.source       out_bus
);

  logic [7:0] half_r;
  logic [7:0] edge_r;

  logic                              busy_r;
  logic                              cond_r;
  logic                              is_stop_r;
  logic [twwg_pkg::SHIFT_W-1:0]      sh_r;
  logic [twwg_pkg::COUNT_W-1:0]      left_r;
  logic [1:0]                        ph_r;

  logic       out_valid_r;
  logic       out_clk_r;
  logic       out_dat_r;
  logic [7:0] out_hold_r;
  logic       out_last_r;

  logic       in_fire;
  logic       gen;
  logic       clk_nxt;
  logic       dat_nxt;
  logic [7:0] hold_nxt;
  logic       last_nxt;
  logic [twwg_pkg::SHIFT_W-1:0] load_sh;
  logic [twwg_pkg::COUNT_W-1:0] load_left;
  logic       load_busy;
  logic       load_cond;

  assign in_bus.ready = !busy_r;
  assign in_fire      = in_bus.valid && !busy_r;
  assign gen          = busy_r && (!out_valid_r || out_bus.ready);

  // Drive the output register
  assign out_bus.valid       = out_valid_r;
  assign out_bus.clock_level = out_clk_r;
  assign out_bus.data_level  = out_dat_r;
  assign out_bus.hold_ticks  = out_hold_r;
  assign out_bus.last_phase  = out_last_r;

  // Decode a command into shifter contents and bit count
  always_comb begin
    load_sh   = '0;
    load_left = '0;
    load_busy = 1'b1;
    load_cond = 1'b0;
    case (in_bus.cmd)
      twwg_pkg::CMD_START, twwg_pkg::CMD_STOP: begin
        load_cond = 1'b1;
      end
      twwg_pkg::CMD_BYTE: begin
        load_sh   = {in_bus.payload[7:0], 1'b0, 9'd0};
        load_left = twwg_pkg::COUNT_W'(9);
      end
      twwg_pkg::CMD_NIBBLE: begin
        load_sh   = {in_bus.payload[3:0], 14'd0};
        load_left = twwg_pkg::COUNT_W'(4);
      end
      twwg_pkg::CMD_BIT: begin
        load_sh   = {in_bus.payload[0], 17'd0};
        load_left = twwg_pkg::COUNT_W'(1);
      end
      twwg_pkg::CMD_WORD: begin
        load_sh   = {in_bus.payload[15:8], 1'b0, in_bus.payload[7:0], 1'b0};
        load_left = twwg_pkg::COUNT_W'(18);
      end
      default: begin
        load_busy = 1'b0;
      end
    endcase
  end

  // Form the next pin phase
  always_comb begin
    clk_nxt  = 1'b0;
    dat_nxt  = 1'b0;
    hold_nxt = 8'd0;
    last_nxt = 1'b0;
    if (cond_r) begin
      last_nxt = (ph_r == twwg_pkg::PH_LOW);
      case (ph_r)
        twwg_pkg::PH_SETUP: begin
          clk_nxt  = !is_stop_r;
          dat_nxt  = !is_stop_r;
          hold_nxt = edge_r;
        end
        twwg_pkg::PH_HIGH: begin
          clk_nxt  = 1'b1;
          dat_nxt  = 1'b0;
          hold_nxt = edge_r;
        end
        default: begin
          clk_nxt  = is_stop_r;
          dat_nxt  = is_stop_r;
          hold_nxt = 8'd0;
        end
      endcase
    end else begin
      clk_nxt  = (ph_r == twwg_pkg::PH_HIGH);
      dat_nxt  = sh_r[twwg_pkg::SHIFT_W-1];
      hold_nxt = (ph_r == twwg_pkg::PH_LOW) ? 8'd0 : half_r;
      last_nxt = (ph_r == twwg_pkg::PH_LOW) && (left_r == twwg_pkg::COUNT_W'(1));
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= twwg_pkg::BIT_HALF_PERIOD_RST;
      edge_r <= twwg_pkg::EDGE_SETUP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        twwg_pkg::CFG_BIT_HALF_PERIOD: half_r <= cfg_data;
        twwg_pkg::CFG_EDGE_SETUP_TIME: edge_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the sequencer and shifter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= twwg_pkg::PH_SETUP;
      cond_r <= 1'b0;
    end else if (in_fire) begin
      busy_r    <= load_busy;
      cond_r    <= load_cond;
      is_stop_r <= (in_bus.cmd == twwg_pkg::CMD_STOP);
      sh_r      <= load_sh;
      left_r    <= load_left;
      ph_r      <= twwg_pkg::PH_SETUP;
    end else if (gen) begin
      if (ph_r == twwg_pkg::PH_LOW) begin
        ph_r   <= twwg_pkg::PH_SETUP;
        sh_r   <= {sh_r[twwg_pkg::SHIFT_W-2:0], 1'b0};
        left_r <= left_r - twwg_pkg::COUNT_W'(1);
        if (last_nxt) begin
          busy_r <= 1'b0;
        end
      end else begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  // Load or drop the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (gen) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      out_clk_r  <= clk_nxt;
      out_dat_r  <= dat_nxt;
      out_hold_r <= hold_nxt;
      out_last_r <= last_nxt;
    end
  end

  // Checks
  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != 2'd3)
    else $error("phase counter out of range");

  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !cond_r) |-> (left_r != '0))
    else $error("bit mode busy with no bits left");

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_bus.cmd == twwg_pkg::CMD_START || in_bus.cmd == twwg_pkg::CMD_STOP ||
     in_bus.cmd == twwg_pkg::CMD_BYTE || in_bus.cmd == twwg_pkg::CMD_NIBBLE ||
     in_bus.cmd == twwg_pkg::CMD_BIT || in_bus.cmd == twwg_pkg::CMD_WORD)) |=> busy_r)
    else $error("valid command did not start the sequencer");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_hold_r == 8'd0))
    else $error("final phase carries a hold time");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (gen && last_nxt) |=> !busy_r)
    else $error("sequencer busy after final phase");

endmodule
